/* rtl/core/rlew_pkg.sv */
// ----------------------------------------------------------------------------
// rlew_pkg
// Types and constants shared by the RLEW word run encoder modules.
// ----------------------------------------------------------------------------
package rlew_pkg;

    localparam int unsigned WordW    = 16;
    localparam int unsigned LenW     = 8;
    localparam int unsigned CountW   = 13;
    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

    localparam logic [WordW-1:0] TagWord    = 16'hABCD;
    localparam logic [WordW-1:0] HighMask   = 16'hFF00;
    localparam logic [WordW-1:0] ReservedA  = 16'hA700;
    localparam logic [WordW-1:0] ReservedB  = 16'hA800;
    localparam logic [LenW-1:0]  MaxRunReset = 8'd100;
    localparam logic [LenW-1:0]  LiteralLimit = 8'd3;
    localparam logic [CountW-1:0] CountMax  = '1;

    typedef struct packed {
        logic [WordW-1:0] data_word;
        logic             last_word;
    } t_in_item;

    typedef struct packed {
        logic [WordW-1:0]  code_word;
        logic              end_of_block;
        logic [CountW-1:0] data_word_count;
        logic              reserved_seen;
    } t_out_item;

    // One flushed run, optionally followed by a single trailing literal
    // (the word that ended the previous run on the last word of a block).
    typedef struct packed {
        logic [WordW-1:0] val_a;
        logic [LenW-1:0]  len_a;
        logic             has_b;
        logic [WordW-1:0] val_b;
        logic             last;
        logic             err;
    } t_run_cmd;

endpackage

/* rtl/core/rlew_front.sv */
// ----------------------------------------------------------------------------
// rlew_front
// Run tracker: follows the current run of equal words and issues a run
// command whenever a run closes or the last word of a block is accepted.
// ----------------------------------------------------------------------------
module rlew_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [rlew_pkg::LenW-1:0] i_cfg_wr_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  rlew_pkg::t_in_item      i_item,
    input  logic                    i_q_full,
    output logic                    o_push,
    output rlew_pkg::t_run_cmd      o_cmd
);

    logic [rlew_pkg::LenW-1:0]  r_max_run;
    logic [rlew_pkg::WordW-1:0] r_val, n_val;
    logic [rlew_pkg::LenW-1:0]  r_len, n_len;
    logic                       r_err, n_err;

    logic [rlew_pkg::WordW-1:0] w;
    logic [rlew_pkg::WordW-1:0] hi;
    logic [rlew_pkg::LenW-1:0]  cap;
    logic                       word_err;
    logic                       extend;
    logic                       flush_old;
    logic [rlew_pkg::LenW-1:0]  run_len;
    logic                       accept;

    assign w        = i_item.data_word;
    assign hi       = w & rlew_pkg::HighMask;
    assign word_err = (w == rlew_pkg::TagWord) || (hi == rlew_pkg::ReservedA) ||
                      (hi == rlew_pkg::ReservedB);
    assign cap      = (r_max_run == '0) ? rlew_pkg::LenW'(1) : r_max_run;
    assign extend   = (r_len != '0) && (w == r_val) && (r_len < cap);
    assign flush_old = (r_len != '0) && !extend;
    assign run_len  = extend ? r_len + rlew_pkg::LenW'(1) : rlew_pkg::LenW'(1);

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && (flush_old || i_item.last_word);

    always_comb begin
        n_err = r_err | word_err;
        o_cmd.last  = i_item.last_word;
        o_cmd.err   = n_err;
        o_cmd.val_b = w;
        if (flush_old) begin
            o_cmd.val_a = r_val;
            o_cmd.len_a = r_len;
            o_cmd.has_b = i_item.last_word;
        end else begin
            o_cmd.val_a = w;
            o_cmd.len_a = run_len;
            o_cmd.has_b = 1'b0;
        end
        n_val = r_val;
        n_len = r_len;
        if (accept) begin
            if (i_item.last_word) begin
                n_val = '0;
                n_len = '0;
                n_err = 1'b0;
            end else begin
                n_val = w;
                n_len = run_len;
            end
        end else begin
            n_err = r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_run <= rlew_pkg::MaxRunReset;
            r_val     <= '0;
            r_len     <= '0;
            r_err     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_run <= i_cfg_wr_data;
            end
            r_val <= n_val;
            r_len <= n_len;
            r_err <= n_err;
        end
    end

endmodule

/* rtl/core/rlew_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// rlew_cmd_fifo
// Short queue of run commands between the run tracker and the word emitter.
// ----------------------------------------------------------------------------
module rlew_cmd_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rlew_pkg::t_run_cmd i_cmd,
    input  logic               i_pop,
    output rlew_pkg::t_run_cmd o_cmd,
    output logic               o_full,
    output logic               o_empty
);

    localparam int unsigned PtrW = rlew_pkg::QueuePtrW;
    localparam int unsigned CntW = PtrW + 1;

    rlew_pkg::t_run_cmd r_mem [rlew_pkg::QueueDepth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;

    assign o_full  = (r_count == CntW'(rlew_pkg::QueueDepth));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PtrW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PtrW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CntW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end

endmodule

/* rtl/core/rlew_back.sv */
// ----------------------------------------------------------------------------
// rlew_back
// Word emitter: expands run commands into tag/count/value or literal words
// and keeps the per-block output word count.
// ----------------------------------------------------------------------------
module rlew_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  rlew_pkg::t_run_cmd i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output rlew_pkg::t_out_item o_item
);

    logic                      r_busy;
    rlew_pkg::t_run_cmd        r_cmd;
    logic [1:0]                r_idx;
    logic [rlew_pkg::CountW-1:0] r_cnt;
    logic                      r_out_valid;
    rlew_pkg::t_out_item       r_out;

    logic                      is_tagged;
    logic [1:0]                na;
    logic [2:0]                n_words;
    logic                      on_last;
    logic                      adv;
    logic [rlew_pkg::WordW-1:0] word;
    logic [rlew_pkg::CountW-1:0] cnt_inc;
    logic                      eob;

    assign is_tagged = r_cmd.len_a > rlew_pkg::LiteralLimit;
    assign na      = is_tagged ? 2'd3 : r_cmd.len_a[1:0];
    assign n_words = {1'b0, na} + {2'b00, r_cmd.has_b};
    assign on_last = ({1'b0, r_idx} == n_words - 3'd1);
    assign adv     = r_busy && (!r_out_valid || i_ready);
    assign o_pop   = !i_q_empty && (!r_busy || (adv && on_last));
    assign eob     = on_last && r_cmd.last;
    assign cnt_inc = (r_cnt == rlew_pkg::CountMax) ? r_cnt :
                     r_cnt + rlew_pkg::CountW'(1);

    always_comb begin
        if (r_idx < na) begin
            if (is_tagged && r_idx == 2'd0) begin
                word = rlew_pkg::TagWord;
            end else if (is_tagged && r_idx == 2'd1) begin
                word = {{(rlew_pkg::WordW-rlew_pkg::LenW){1'b0}}, r_cmd.len_a};
            end else begin
                word = r_cmd.val_a;
            end
        end else begin
            word = r_cmd.val_b;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // payload register, no reset
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (adv) begin
            r_out.code_word       <= word;
            r_out.end_of_block    <= eob;
            r_out.data_word_count <= eob ? cnt_inc : '0;
            r_out.reserved_seen   <= eob & r_cmd.err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (adv && on_last) begin
                r_busy <= 1'b0;
                r_idx  <= '0;
            end else if (adv) begin
                r_idx <= r_idx + 2'd1;
            end
            if (adv) begin
                r_cnt       <= eob ? '0 : cnt_inc;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

/* rtl/core/rlew_word_run_encoder_top.sv */
// Path: a closed run passes through the run queue, the emitter's command register
// and its output register. Throughput: one input word per cycle while the queue
// is not full; one output word per cycle from the emitter while the receiver is
// ready; a tagged run emits three words; a 4-entry queue absorbs bursts. Reset:
// synchronous active-low i_rst_n clears run state, queue and output; max_run returns to 100.
// ----------------------------------------------------------------------------
// rlew_word_run_encoder_top
// RLEW 16-bit word run encoder: run tracker, run queue and word emitter.
// ----------------------------------------------------------------------------
module rlew_word_run_encoder_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [rlew_pkg::LenW-1:0] i_cfg_wr_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  rlew_pkg::t_in_item       i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output rlew_pkg::t_out_item      o_out_data
);

    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    rlew_pkg::t_run_cmd push_cmd;
    rlew_pkg::t_run_cmd pop_cmd;

    rlew_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_item        (i_in_data),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_cmd         (push_cmd)
    );

    rlew_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_cmd   (pop_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    rlew_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_cmd     (pop_cmd),
        .o_pop     (q_pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_item    (o_out_data)
    );

endmodule

/* verif/rlew_encode_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlew_encode_checker
// Watches the word and code channels of the run encoder. It keeps its own run
// tracker, builds the code words each accepted word must produce, and compares
// every code-word transfer field by field against the oldest one outstanding.
// ----------------------------------------------------------------------------
module rlew_encode_checker
    import rlew_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [LenW-1:0]   i_cfg_wr_data,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  t_in_item          i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  t_out_item         i_out_data,
    input  logic              i_end_check,
    output int                o_fail_count,
    output int                o_pending
);

    logic [LenW-1:0]   max_run_q;
    logic [WordW-1:0]  run_val;
    logic [LenW-1:0]   run_len;
    logic [CountW-1:0] words_out;
    logic              reserved_flag;
    t_out_item         expected_codes[$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] ERROR: %s", $realtime, msg);
        o_fail_count = o_fail_count + 1;
    endtask

    function automatic void emit_code(input logic [WordW-1:0] w);
        t_out_item c;
        c = '0;
        c.code_word = w;
        expected_codes.push_back(c);
        if (words_out != CountMax) begin
            words_out = words_out + 1'b1;
        end
    endfunction

    // runs longer than the literal limit collapse to tag, count, value
    function automatic void close_run();
        if (run_len > LiteralLimit) begin
            emit_code(TagWord);
            emit_code({{(WordW-LenW){1'b0}}, run_len});
            emit_code(run_val);
        end else begin
            for (int k = 0; k < int'(run_len); k++) begin
                emit_code(run_val);
            end
        end
        run_len = '0;
    endfunction

    function automatic void encode_word(input t_in_item it);
        logic [LenW-1:0] cap;
        t_out_item       tail;
        cap = (max_run_q == '0) ? LenW'(1) : max_run_q;
        if (it.data_word == TagWord ||
            (it.data_word & HighMask) == ReservedA ||
            (it.data_word & HighMask) == ReservedB) begin
            reserved_flag = 1'b1;
        end
        if (run_len == '0) begin
            run_val = it.data_word;
            run_len = LenW'(1);
        end else if (it.data_word == run_val && run_len < cap) begin
            run_len = run_len + 1'b1;
        end else begin
            close_run();
            run_val = it.data_word;
            run_len = LenW'(1);
        end
        if (it.last_word) begin
            close_run();
            // the block summary rides on the final code word
            tail = expected_codes.pop_back();
            tail.end_of_block    = 1'b1;
            tail.data_word_count = words_out;
            tail.reserved_seen   = reserved_flag;
            expected_codes.push_back(tail);
            run_val       = '0;
            run_len       = '0;
            words_out     = '0;
            reserved_flag = 1'b0;
        end
    endfunction

    task automatic check_code(input t_out_item got);
        t_out_item want;
        if (expected_codes.size() == 0) begin
            report_mismatch($sformatf("code word %h with nothing outstanding", got.code_word));
        end else begin
            want = expected_codes.pop_front();
            if (got.code_word !== want.code_word) begin
                report_mismatch($sformatf("code_word got %h want %h",
                                          got.code_word, want.code_word));
            end
            if (got.end_of_block !== want.end_of_block) begin
                report_mismatch($sformatf("end_of_block got %b want %b (code %h)",
                                          got.end_of_block, want.end_of_block,
                                          want.code_word));
            end
            if (got.data_word_count !== want.data_word_count) begin
                report_mismatch($sformatf("data_word_count got %0d want %0d",
                                          got.data_word_count, want.data_word_count));
            end
            if (got.reserved_seen !== want.reserved_seen) begin
                report_mismatch($sformatf("reserved_seen got %b want %b",
                                          got.reserved_seen, want.reserved_seen));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            max_run_q     = MaxRunReset;
            run_val       = '0;
            run_len       = '0;
            words_out     = '0;
            reserved_flag = 1'b0;
            expected_codes.delete();
            o_fail_count  = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_code(i_out_data);
            end
            if (i_cfg_wr_en) begin
                max_run_q = i_cfg_wr_data;
            end
            if (i_in_valid && i_in_ready) begin
                encode_word(i_in_data);
            end
            if (i_end_check && expected_codes.size() != 0) begin
                report_mismatch($sformatf("%0d code words never arrived",
                                          expected_codes.size()));
            end
        end
        o_pending <= expected_codes.size();
    end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the RLEW word run encoder. Directed blocks hit
// literal and tagged runs, run caps and reserved words; random blocks follow
// under several max_run settings, with bursty input, a stalling receiver and
// a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import rlew_pkg::*;

    localparam int WatchdogLimit = 2000;
    localparam int HoldCycles    = 80;
    localparam int PhaseItems    = 6;

    // receiver stall patterns
    localparam int RcvAlways = 0;
    localparam int RcvHalf   = 1;
    localparam int RcvMostly = 2;
    localparam int RcvSparse = 3;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [LenW-1:0]   cfg_wr_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    t_in_item          in_data = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    t_out_item         out_data;
    logic              end_check = 1'b0;
    int                fail_count;
    int                pending;

    bit                hold_req = 1'b0;
    bit                rcv_steady = 1'b0;
    bit                gaps_on = 1'b1;
    int                burst_left = 0;
    int                max_run_now = MaxRunReset;
    int                phase_items = 0;

    rlew_word_run_encoder_top u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_in_data     (in_data),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_out_data    (out_data)
    );

    rlew_encode_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .i_end_check   (end_check),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // receiver: switches between randomly chosen stall patterns; a hold request
    // drops ready for a long stretch
    initial begin
        int mode;
        int mode_left;
        int hold_left;
        mode      = RcvAlways;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_left = HoldCycles;
                hold_req  = 1'b0;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(RcvAlways, RcvSparse);
                mode_left = $urandom_range(16, 96);
            end else begin
                mode_left--;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (rcv_steady) begin
                out_ready <= 1'b1;
            end else begin
                case (mode)
                    RcvAlways: out_ready <= 1'b1;
                    RcvHalf:   out_ready <= 1'($urandom_range(0, 1));
                    RcvMostly: out_ready <= ($urandom_range(0, 4) != 0);
                    default:   out_ready <= (mode_left[1:0] == 2'd0);
                endcase
            end
        end
    end

    // no transfer on either channel for too long ends the run
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WatchdogLimit) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("tb_top NOT OK");
        $finish;
    end

    task automatic send_word(input logic [WordW-1:0] w, input logic last);
        t_in_item it;
        int       gap;
        it.data_word = w;
        it.last_word = last;
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (gaps_on && burst_left == 0) begin
            gap        = $urandom_range(1, 12);
            burst_left = $urandom_range(0, 20);
            in_valid  <= 1'b0;
            repeat (gap) @(posedge clk);
        end else if (burst_left != 0) begin
            burst_left--;
        end
    endtask

    task automatic send_run(input logic [WordW-1:0] w, input int n, input logic last);
        for (int k = 0; k < n; k++) begin
            send_word(w, last && (k == n - 1));
        end
    endtask

    // pause input until every outstanding code word is out, then let it go quiet
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_max_run(input int v);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= LenW'(v);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        max_run_now = v;
    endtask

    function automatic logic [WordW-1:0] pick_word();
        logic [WordW-1:0] w;
        case ($urandom_range(0, 19))
            12, 13:  w = 16'h0000;
            14:      w = 16'hFFFF;
            15:      w = 16'h8001;
            16:      w = 16'h00FF;
            17:      w = TagWord;
            18:      w = {ReservedA[15:8], 8'($urandom_range(0, 255))};
            19:      w = {ReservedB[15:8], 8'($urandom_range(0, 255))};
            default: w = 16'($urandom_range(0, 65535));
        endcase
        return w;
    endfunction

    function automatic int pick_len();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return $urandom_range(1, 3);
        if (sel < 9 || max_run_now > 40) return $urandom_range(4, 8);
        return $urandom_range(max_run_now - 1, max_run_now + 2);
    endfunction

    task automatic random_block();
        int n_runs;
        int len;
        logic [WordW-1:0] w;
        n_runs = $urandom_range(1, 8);
        for (int r = 0; r < n_runs; r++) begin
            w   = pick_word();
            len = pick_len();
            send_run(w, len, r == n_runs - 1);
            phase_items += len;
        end
    endtask

    task automatic random_phase(input int max_run);
        set_max_run(max_run);
        phase_items = 0;
        while (phase_items < PhaseItems) random_block();
    endtask

    initial begin
        burst_left = $urandom_range(0, 20);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default cap: literal runs of one to three, a tagged run, reserved words
        send_word(16'h0000, 1'b0);
        send_run(16'hFFFF, 2, 1'b0);
        send_run(16'h1234, 3, 1'b0);
        send_run(16'h5555, 4, 1'b0);
        send_word(TagWord, 1'b0);
        send_word(16'hA700, 1'b0);
        send_word(16'hA8FF, 1'b1);

        // cap of four: a run splits at four; then a one-word block
        set_max_run(4);
        send_run(16'h00AA, 9, 1'b0);
        send_word(16'h7777, 1'b1);
        send_word(16'h8001, 1'b1);

        // largest cap: a tagged run well under the cap, closed by the last word
        set_max_run(255);
        send_run(16'h3C3C, 7, 1'b0);
        send_word(16'hC3C3, 1'b1);

        random_phase(MaxRunReset);
        random_phase(4);

        // receiver holds off while the sender keeps offering distinct words
        settle();
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        for (int k = 0; k < 24; k++) begin
            send_word(16'($urandom_range(0, 65535)) ^ 16'(k), k == 23);
        end
        gaps_on = 1'b1;

        random_phase(255);
        random_phase($urandom_range(5, 16));

        // stretch with no idling on either side
        settle();
        rcv_steady = 1'b1;
        gaps_on    = 1'b0;
        phase_items = 0;
        while (phase_items < PhaseItems) random_block();
        rcv_steady = 1'b0;
        gaps_on    = 1'b1;

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        end_check <= 1'b1;
        @(posedge clk);
        end_check <= 1'b0;
        repeat (2) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
